// ----- hw/rtl/sorted_top_k_score_table_top_assert.svh -----
// Assertion helpers for the score table top level.
`ifndef SORTED_TOP_K_SCORE_TABLE_TOP_ASSERT_SVH
`define SORTED_TOP_K_SCORE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STK_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define STK_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hw/rtl/stk_pkg.sv -----
package stk_pkg;

  localparam int NAME_W  = 64;
  localparam int SCORE_W = 32;
  localparam int RIDX_W  = 4;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 5'd10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Item classes decided by the front end.
  localparam logic [1:0] CLS_INSERT = 2'd0;
  localparam logic [1:0] CLS_READ   = 2'd1;
  localparam logic [1:0] CLS_NOP    = 2'd2;

  typedef struct packed {
    logic [1:0]                cls;
    logic [RIDX_W-1:0]         read_index;
    logic [NAME_W-1:0]         name_tag;
    logic signed [SCORE_W-1:0] new_score;
  } cmd_t;

  typedef struct packed {
    logic                      placed;
    logic [POS_W-1:0]          position;
    logic                      entry_valid;
    logic [NAME_W-1:0]         entry_name;
    logic signed [SCORE_W-1:0] entry_score;
    logic [COUNT_W-1:0]        entry_count;
  } res_t;

endpackage

// ----- hw/rtl/stk_front.sv -----
module stk_front #(
  parameter int TAG_BITS = 64
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_push,
  output logic                                       in_full,
  input  logic                                       in_operation,
  input  logic [stk_pkg::RIDX_W-1:0]                 in_read_index,
  input  logic [stk_pkg::NAME_W-1:0]                 in_name_tag,
  input  logic signed [stk_pkg::SCORE_W-1:0]         in_new_score,
  output logic                                       cmd_empty,
  input  logic                                       cmd_pop,
  output stk_pkg::cmd_t                              cmd_out
);

  localparam logic [stk_pkg::NAME_W-1:0] TAG_MASK =
    {stk_pkg::NAME_W{1'b1}} >> (stk_pkg::NAME_W - TAG_BITS);

  stk_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push_ok;
  stk_pkg::cmd_t cmd_new;

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_empty = (cnt_r == 2'd0);
  assign push_ok   = in_push && !in_full;
  assign cmd_out   = q_r[rd_ptr_r];

  always_comb begin
    cmd_new.read_index = in_read_index;
    cmd_new.name_tag   = in_name_tag & TAG_MASK;
    cmd_new.new_score  = in_new_score;
    if (in_operation == stk_pkg::OP_READ) begin
      cmd_new.cls = stk_pkg::CLS_READ;
    end else if (in_new_score == '0) begin
      cmd_new.cls = stk_pkg::CLS_NOP;
    end else begin
      cmd_new.cls = stk_pkg::CLS_INSERT;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ (cmd_pop && !cmd_empty);
    cnt_nxt    = cnt_r + 2'(push_ok) - 2'(cmd_pop && !cmd_empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

// ----- hw/rtl/stk_table.sv -----
module stk_table #(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [stk_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           cmd_empty,
  output logic                           cmd_pop,
  input  stk_pkg::cmd_t                  cmd_in,
  input  logic                           res_full,
  output logic                           res_push,
  output stk_pkg::res_t                  res_out
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  stk_pkg::cmd_t                     cmd_r, cmd_nxt;
  logic [CAPACITY-1:0]               gt_r, gt_nxt;
  logic [CNT_W-1:0]                  held_r, held_nxt;
  logic [IDX_W-1:0]                  latest_r, latest_nxt;
  logic [stk_pkg::CFG_W-1:0]         max_r;

  logic [TAG_BITS-1:0]               tag_r   [CAPACITY];
  logic signed [stk_pkg::SCORE_W-1:0] score_r [CAPACITY];

  logic [CNT_W-1:0]    limit;
  logic                grow;
  logic                any_gt;
  logic [IDX_W-1:0]    first_gt;
  logic [CAPACITY-1:0] ahead;
  logic [CAPACITY-1:0] ins;
  logic [CAPACITY-1:0] shift;
  logic                do_insert;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_hit;

  function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] v);
    logic [IDX_W-1:0] pos;
    pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = IDX_W'(i);
      end
    end
    return pos;
  endfunction

  always_comb begin
    if (32'(max_r) > 32'(CAPACITY)) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(max_r);
    end
  end

  assign grow     = (held_r < limit);
  assign any_gt   = |gt_r;
  assign first_gt = first_set(gt_r);

  // ahead[a]: the new entry lands above slot a, so slot a takes its upper neighbor
  always_comb begin
    ahead[0] = 1'b0;
    for (int a = 1; a < CAPACITY; a++) begin
      ahead[a] = ahead[a-1] | gt_r[a-1];
    end
  end

  always_comb begin
    for (int a = 0; a < CAPACITY; a++) begin
      ins[a]   = (gt_r[a] && !ahead[a]) ||
                 (!any_gt && grow && (CNT_W'(a) == held_r));
      shift[a] = ahead[a] && (CNT_W'(a) < held_nxt);
    end
  end

  assign rd_idx = IDX_W'(cmd_r.read_index);
  assign rd_hit = (32'(cmd_r.read_index) < 32'(held_r));

  assign do_insert = (state_r == ST_EXEC) && (cmd_r.cls == stk_pkg::CLS_INSERT);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    gt_nxt     = gt_r;
    held_nxt   = held_r;
    latest_nxt = latest_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // output queue room is checked here; only this engine fills it
        if (!cmd_empty && !res_full) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_in;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        for (int i = 0; i < CAPACITY; i++) begin
          gt_nxt[i] = (CNT_W'(i) < held_r) && (cmd_r.new_score > score_r[i]);
        end
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
        if (cmd_r.cls == stk_pkg::CLS_INSERT) begin
          held_nxt = held_r + CNT_W'(grow);
          if (any_gt) begin
            latest_nxt = first_gt;
          end else if (grow) begin
            latest_nxt = IDX_W'(held_r);
          end else if (held_r == '0) begin
            latest_nxt = '0;
          end else begin
            latest_nxt = IDX_W'(held_r - CNT_W'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_out.placed      = 1'b0;
    res_out.position    = stk_pkg::POS_W'(latest_nxt);
    res_out.entry_valid = 1'b0;
    res_out.entry_name  = '0;
    res_out.entry_score = '0;
    res_out.entry_count = stk_pkg::COUNT_W'(held_nxt);
    if (cmd_r.cls == stk_pkg::CLS_INSERT) begin
      res_out.placed = any_gt || grow;
    end else if (cmd_r.cls == stk_pkg::CLS_READ && rd_hit) begin
      res_out.entry_valid = 1'b1;
      res_out.entry_name  = stk_pkg::NAME_W'(tag_r[rd_idx]);
      res_out.entry_score = score_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      held_r   <= '0;
      latest_r <= '0;
      max_r    <= stk_pkg::MAX_ENTRIES_RESET;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      latest_r <= latest_nxt;
      if (cfg_we) begin
        max_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    gt_r  <= gt_nxt;
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      if (ins[0]) begin
        tag_r[0]   <= cmd_r.name_tag[TAG_BITS-1:0];
        score_r[0] <= cmd_r.new_score;
      end
      for (int a = 1; a < CAPACITY; a++) begin
        if (ins[a]) begin
          tag_r[a]   <= cmd_r.name_tag[TAG_BITS-1:0];
          score_r[a] <= cmd_r.new_score;
        end else if (shift[a]) begin
          tag_r[a]   <= tag_r[a-1];
          score_r[a] <= score_r[a-1];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/stk_outq.sv -----
module stk_outq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               res_push,
  input  stk_pkg::res_t                      res_in,
  output logic                               res_full,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic                               out_placed,
  output logic [stk_pkg::POS_W-1:0]          out_position,
  output logic                               out_entry_valid,
  output logic [stk_pkg::NAME_W-1:0]         out_entry_name,
  output logic signed [stk_pkg::SCORE_W-1:0] out_entry_score,
  output logic [stk_pkg::COUNT_W-1:0]        out_entry_count
);

  stk_pkg::res_t q_r [2];
  stk_pkg::res_t head;
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push_ok;
  logic          pop_ok;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign push_ok   = res_push && !res_full;
  assign pop_ok    = out_pop && !out_empty;
  assign head      = q_r[rd_ptr_r];

  assign out_placed      = head.placed;
  assign out_position    = head.position;
  assign out_entry_valid = head.entry_valid;
  assign out_entry_name  = head.entry_name;
  assign out_entry_score = head.entry_score;
  assign out_entry_count = head.entry_count;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    cnt_nxt    = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= res_in;
    end
  end

endmodule

// ----- hw/rtl/sorted_top_k_score_table_top.sv -----
// Sorted top-k score table. Inserts keep the table ordered by score, highest
// first; a tie goes behind the entries already held. Each beat pushed in gives
// exactly one result beat. A two-deep command queue feeds a table engine that
// handles each item in turn (load, compare against all entries, then
// shift-insert or read) and takes no new item before the last is done.
// Results wait in a two-deep output queue. max_entries resets to 10 and is
// written through cfg_ (always ready); the user must write it only while no
// item is in flight, since the block itself does not enforce this.
`include "sorted_top_k_score_table_top_assert.svh"

module sorted_top_k_score_table_top #(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_operation,
  input  logic [stk_pkg::RIDX_W-1:0]         in_read_index,
  input  logic [stk_pkg::NAME_W-1:0]         in_name_tag,
  input  logic signed [stk_pkg::SCORE_W-1:0] in_new_score,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic                               out_placed,
  output logic [stk_pkg::POS_W-1:0]          out_position,
  output logic                               out_entry_valid,
  output logic [stk_pkg::NAME_W-1:0]         out_entry_name,
  output logic signed [stk_pkg::SCORE_W-1:0] out_entry_score,
  output logic [stk_pkg::COUNT_W-1:0]        out_entry_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [stk_pkg::CFG_W-1:0]          cfg_max_entries
);

  logic          cmd_empty;
  logic          cmd_pop;
  stk_pkg::cmd_t cmd;
  logic          res_full;
  logic          res_push;
  stk_pkg::res_t res;

  assign cfg_ready = 1'b1;

  stk_front #(
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_operation  (in_operation),
    .in_read_index (in_read_index),
    .in_name_tag   (in_name_tag),
    .in_new_score  (in_new_score),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .cmd_out       (cmd)
  );

  stk_table #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_max_entries),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_in    (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_out   (res)
  );

  stk_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_push        (res_push),
    .res_in          (res),
    .res_full        (res_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_placed      (out_placed),
    .out_position    (out_position),
    .out_entry_valid (out_entry_valid),
    .out_entry_name  (out_entry_name),
    .out_entry_score (out_entry_score),
    .out_entry_count (out_entry_count)
  );

  // engine never produces into a full result queue
  `STK_ASSERT_IMPLY(a_no_res_overflow, res_push, !res_full, "result pushed into full queue")
  // a beat is taken from the command queue only when one is there, and work follows
  `STK_ASSERT_NEXT(a_pop_starts_work, cmd_pop, !cmd_pop && !res_push, "engine overlapped items")
  `STK_ASSERT_IMPLY(a_place_or_read, res_push, !(res.placed && res.entry_valid),
                    "result both placed and read")
  `STK_ASSERT_IMPLY(a_invalid_read_zero, res_push && !res.entry_valid,
                    res.entry_name == '0 && res.entry_score == '0,
                    "invalid read returned nonzero data")

endmodule

// ----- dv/sorted_top_k_score_table_top_tb.sv -----
module sorted_top_k_score_table_top_tb;
  import stk_pkg::*;

  localparam int CAPACITY = 16;
  localparam int TAG_BITS = 64;

  // Ranked table predictor plus the queue of result beats still owed by the block.
  class table_scoreboard;
    logic [NAME_W-1:0]         tags[CAPACITY];
    logic signed [SCORE_W-1:0] scores[CAPACITY];
    int                        held;
    logic [POS_W-1:0]          last_pos;
    logic [CFG_W-1:0]          limit_reg;
    res_t                      owed_rows[$];
    int                        errors;

    function new();
      held      = 0;
      last_pos  = '0;
      limit_reg = MAX_ENTRIES_RESET;
      errors    = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit_reg = v;
    endfunction

    function int pending();
      return owed_rows.size();
    endfunction

    function res_t rank_item(logic op, logic [RIDX_W-1:0] ridx, logic [NAME_W-1:0] tag,
                             logic signed [SCORE_W-1:0] score);
      res_t r;
      int   slot;
      int   lim;
      int   a;
      r = '0;
      if (op == OP_INSERT) begin
        if (score != 0) begin
          // ties stay behind entries already held
          slot = 0;
          while (slot < held && score <= scores[slot]) slot++;
          lim = (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
          if (held < lim) held++;
          if (slot < held) begin
            for (a = held - 1; a > slot; a--) begin
              tags[a]   = tags[a-1];
              scores[a] = scores[a-1];
            end
            tags[slot]   = tag;
            scores[slot] = score;
            last_pos     = slot[POS_W-1:0];
            r.placed     = 1'b1;
          end else begin
            last_pos = (held > 0) ? POS_W'(held - 1) : '0;
          end
        end
      end else if (ridx < held) begin
        r.entry_valid = 1'b1;
        r.entry_name  = tags[ridx];
        r.entry_score = scores[ridx];
      end
      r.position    = last_pos;
      r.entry_count = held[COUNT_W-1:0];
      return r;
    endfunction

    function void note_item(logic op, logic [RIDX_W-1:0] ridx, logic [NAME_W-1:0] tag,
                            logic signed [SCORE_W-1:0] score);
      owed_rows.push_back(rank_item(op, ridx, tag, score));
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (owed_rows.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      exp = owed_rows.pop_front();
      if (got.placed !== exp.placed) begin
        $error("placed: expected %0b, got %0b", exp.placed, got.placed);
        errors++;
      end
      if (got.position !== exp.position) begin
        $error("position: expected %0d, got %0d", exp.position, got.position);
        errors++;
      end
      if (got.entry_valid !== exp.entry_valid) begin
        $error("entry_valid: expected %0b, got %0b", exp.entry_valid, got.entry_valid);
        errors++;
      end
      if (got.entry_name !== exp.entry_name) begin
        $error("entry_name: expected %h, got %h", exp.entry_name, got.entry_name);
        errors++;
      end
      if (got.entry_score !== exp.entry_score) begin
        $error("entry_score: expected %0d, got %0d", exp.entry_score, got.entry_score);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_push;
  logic                      in_full;
  logic                      in_operation;
  logic [RIDX_W-1:0]         in_read_index;
  logic [NAME_W-1:0]         in_name_tag;
  logic signed [SCORE_W-1:0] in_new_score;
  logic                      out_empty;
  logic                      out_pop;
  logic                      out_placed;
  logic [POS_W-1:0]          out_position;
  logic                      out_entry_valid;
  logic [NAME_W-1:0]         out_entry_name;
  logic signed [SCORE_W-1:0] out_entry_score;
  logic [COUNT_W-1:0]        out_entry_count;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_W-1:0]          cfg_max_entries;

  table_scoreboard sb;
  bit              steady;
  int              hold_left;

  sorted_top_k_score_table_top #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_read_index   (in_read_index),
    .in_name_tag     (in_name_tag),
    .in_new_score    (in_new_score),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_placed      (out_placed),
    .out_position    (out_position),
    .out_entry_valid (out_entry_valid),
    .out_entry_name  (out_entry_name),
    .out_entry_score (out_entry_score),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_entries (cfg_max_entries)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones; none while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3, 4, 5: begin
        // narrow band so ties happen often
        v = $urandom_range(0, 16);
        return v - 8;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic op, logic [RIDX_W-1:0] ridx, logic [NAME_W-1:0] tag,
                           logic signed [SCORE_W-1:0] score);
    int gap;
    in_push       <= 1'b1;
    in_operation  <= op;
    in_read_index <= ridx;
    in_name_tag   <= tag;
    in_new_score  <= score;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_item(op, ridx, tag, score);
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    drain();
    cfg_valid       <= 1'b1;
    cfg_max_entries <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic read_at(logic [RIDX_W-1:0] ridx);
    send_item(OP_READ, ridx, {$urandom, $urandom}, $urandom);
  endtask

  task automatic insert_score(logic [NAME_W-1:0] tag, logic signed [SCORE_W-1:0] score);
    send_item(OP_INSERT, RIDX_W'($urandom_range(0, 15)), tag, score);
  endtask

  // result side: check each popped beat, then decide pop for the next edge
  always @(posedge clk) begin
    if (out_pop && !out_empty)
      sb.check_result('{out_placed, out_position, out_entry_valid, out_entry_name,
                        out_entry_score, out_entry_count});
    if (!rst_n) begin
      out_pop   <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left--;
    end else begin
      out_pop   <= 1'b1;
      hold_left = pick_gap();
    end
  end

  initial begin
    logic [CFG_W-1:0] limits[11];
    int               n;
    logic             op;
    sb              = new();
    steady          = 1'b0;
    rst_n           <= 1'b0;
    in_push         <= 1'b0;
    in_operation    <= OP_INSERT;
    in_read_index   <= '0;
    in_name_tag     <= '0;
    in_new_score    <= '0;
    cfg_valid       <= 1'b0;
    cfg_max_entries <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero limit on an empty table: nothing can be placed
    write_limit(5'd0);
    insert_score('1, 32'sd5);
    insert_score('1, 32'sd0);
    read_at(4'd0);

    write_limit(5'd3);
    insert_score('1, 32'sh7fffffff);
    insert_score('0, 32'sh80000000);
    insert_score(64'h00000000_0000000a, 32'sd5);
    insert_score(64'h00000000_0000000b, 32'sd5);   // tie goes behind
    insert_score(64'h5555_5555_5555_5555, 32'sd0);
    insert_score(64'haaaa_aaaa_aaaa_aaaa, 32'sh80000000);   // below a full table
    insert_score(64'h00000000_0000000c, 32'sd6);   // last entry drops off
    read_at(4'd0);
    read_at(4'd1);
    read_at(4'd2);
    read_at(4'd3);
    read_at(4'd15);

    // limit below the count: no growth, no removal
    write_limit(5'd1);
    insert_score(64'h1234_5678_9abc_def0, 32'sd7);
    insert_score(64'h0fed_cba9_8765_4321, -32'sd1);
    read_at(4'd2);

    // limit above capacity acts as capacity
    write_limit(5'd31);
    insert_score(64'hffff_0000_ffff_0000, 32'sd1);
    read_at(4'd3);
    read_at(4'd15);

    limits = '{5'd16, 5'd31, 5'd2, 5'd1, 5'd5, 5'd16, 5'd0, 5'd10, 5'd31, 5'd7, 5'd3};
    foreach (limits[p]) begin
      write_limit(limits[p]);
      steady = (p % 3 == 2);
      for (n = 0; n < 130; n++) begin
        op = ($urandom_range(0, 99) < 60) ? OP_INSERT : OP_READ;
        send_item(op, RIDX_W'($urandom_range(0, 15)), {$urandom, $urandom}, pick_score());
      end
    end
    steady = 1'b0;

    drain();
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/stk_pkg.sv
hw/rtl/stk_front.sv
hw/rtl/stk_table.sv
hw/rtl/stk_outq.sv
hw/rtl/sorted_top_k_score_table_top.sv
dv/sorted_top_k_score_table_top_tb.sv
